// ===== rtl/lz77d_pkg.sv =====
// Shared types and constants for the LZ77 type-0x10 decompressor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lz77d_pkg;

    localparam int WINDOW_DEPTH_DEF = 4096;
    localparam int SIZE_W           = 24;
    localparam int CNT_W            = 5;
    localparam int DIST_W           = 13;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]       HDR_MAGIC = 8'h10;
    localparam logic [CNT_W-1:0] MIN_MATCH = 5'd3;
    localparam logic [3:0]       FLAG_BITS = 4'd8;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_MATCH,
        CMD_ERR,
        CMD_ZERO
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [7:0]          data;
        logic [SIZE_W-1:0]   pos;
        logic [DIST_W-1:0]   offset;
        logic [CNT_W-1:0]    count;
        logic                done;
    } cmd_t;

endpackage

// ===== rtl/lz77d_front.sv =====
// Stream parser: header, size, flag bytes and tokens into copy commands.
// Depends on lz77d_pkg; feeds lz77d_cmd_queue.
`timescale 1ns / 1ps

module lz77d_front
    import lz77d_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_frame_start,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_push_data
);

    typedef enum logic [2:0] {
        F_WAIT,
        F_SIZE0,
        F_SIZE1,
        F_SIZE2,
        F_FLAG,
        F_TOKEN,
        F_MATCH_LO
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [7:0]        flag_reg, flag_next;
    logic [3:0]        left_reg, left_next;
    logic [SIZE_W-1:0] total_reg, total_next;
    logic [SIZE_W-1:0] bw_reg, bw_next;
    logic [7:0]        mhigh_reg, mhigh_next;

    logic              accept;
    logic [SIZE_W-1:0] rem;
    logic [SIZE_W-1:0] size_full;
    logic [CNT_W-1:0]  mcount;
    logic [CNT_W-1:0]  ncopy;
    logic [DIST_W-1:0] mdist;
    logic              mdone;
    logic              finished;
    logic [3:0]        left_dec;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign rem       = total_reg - bw_reg;
    assign size_full = {s_in_byte, total_reg[15:0]};
    assign mcount    = {1'b0, mhigh_reg[7:4]} + MIN_MATCH;
    assign mdist     = {1'b0, mhigh_reg[3:0], s_in_byte} + DIST_W'(1);
    assign mdone     = rem <= {{(SIZE_W-CNT_W){1'b0}}, mcount};
    assign ncopy     = (rem < {{(SIZE_W-CNT_W){1'b0}}, mcount}) ? rem[CNT_W-1:0] : mcount;
    assign left_dec  = (left_reg != 4'd0) ? left_reg - 4'd1 : left_reg;

    always_comb begin
        phase_next  = phase_reg;
        flag_next   = flag_reg;
        left_next   = left_reg;
        total_next  = total_reg;
        bw_next     = bw_reg;
        mhigh_next  = mhigh_reg;
        q_push      = 1'b0;
        q_push_data = '{kind: CMD_LIT, data: s_in_byte, pos: bw_reg, offset: mdist,
                        count: CNT_W'(1), done: 1'b0};
        finished    = 1'b0;
        if (accept) begin
            if (s_frame_start) begin
                flag_next  = '0;
                left_next  = '0;
                total_next = '0;
                bw_next    = '0;
                mhigh_next = '0;
                if (s_in_byte == HDR_MAGIC) begin
                    phase_next = F_SIZE0;
                end else begin
                    phase_next       = F_WAIT;
                    q_push           = 1'b1;
                    q_push_data.kind = CMD_ERR;
                end
            end else begin
                unique case (phase_reg)
                    F_WAIT: begin
                    end
                    F_SIZE0: begin
                        total_next = {16'd0, s_in_byte};
                        phase_next = F_SIZE1;
                    end
                    F_SIZE1: begin
                        total_next[15:8] = s_in_byte;
                        phase_next       = F_SIZE2;
                    end
                    F_SIZE2: begin
                        total_next = size_full;
                        if (size_full == '0) begin
                            phase_next       = F_WAIT;
                            q_push           = 1'b1;
                            q_push_data.kind = CMD_ZERO;
                        end else begin
                            phase_next = F_FLAG;
                        end
                    end
                    F_FLAG: begin
                        flag_next  = s_in_byte;
                        left_next  = FLAG_BITS;
                        phase_next = F_TOKEN;
                    end
                    F_TOKEN: begin
                        if (flag_reg[7]) begin
                            mhigh_next = s_in_byte;
                            phase_next = F_MATCH_LO;
                        end else begin
                            q_push           = 1'b1;
                            q_push_data.done = rem == SIZE_W'(1);
                            bw_next          = bw_reg + SIZE_W'(1);
                            finished         = rem == SIZE_W'(1);
                            flag_next        = {flag_reg[6:0], 1'b0};
                            left_next        = left_dec;
                            phase_next       = finished ? F_WAIT :
                                               (left_dec == 4'd0) ? F_FLAG : F_TOKEN;
                        end
                    end
                    F_MATCH_LO: begin
                        q_push            = 1'b1;
                        q_push_data.kind  = CMD_MATCH;
                        q_push_data.count = ncopy;
                        q_push_data.done  = mdone;
                        bw_next           = bw_reg + {{(SIZE_W-CNT_W){1'b0}}, ncopy};
                        finished          = mdone;
                        flag_next         = {flag_reg[6:0], 1'b0};
                        left_next         = left_dec;
                        phase_next        = finished ? F_WAIT :
                                            (left_dec == 4'd0) ? F_FLAG : F_TOKEN;
                    end
                    default: phase_next = F_WAIT;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= F_WAIT;
            flag_reg  <= '0;
            left_reg  <= '0;
            total_reg <= '0;
            bw_reg    <= '0;
            mhigh_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            flag_reg  <= flag_next;
            left_reg  <= left_next;
            total_reg <= total_next;
            bw_reg    <= bw_next;
            mhigh_reg <= mhigh_next;
        end
    end

endmodule

// ===== rtl/lz77d_cmd_queue.sv =====
// Small command FIFO between parser and copy engine.
// Depends on lz77d_pkg for cmd_t and depth constants.
`timescale 1ns / 1ps

module lz77d_cmd_queue
    import lz77d_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_data
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/lz77d_back.sv =====
// Copy engine: executes commands against the history window, drives results.
// Depends on lz77d_pkg; consumes lz77d_cmd_queue output.
`timescale 1ns / 1ps

module lz77d_back
    import lz77d_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  cmd_t       q_data,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_data_valid,
    output logic       m_run_last,
    output logic       m_stream_done,
    output logic       m_header_error
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_EMIT
    } bstate_t;

    bstate_t           state_reg, state_next;
    logic [SIZE_W-1:0] pos_reg, pos_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic              far_reg, far_next;

    logic              m_valid_reg, m_valid_next;
    logic [7:0]        byte_reg, byte_next;
    logic              dv_reg, dv_next;
    logic              last_reg, last_next;
    logic              sd_reg, sd_next;
    logic              err_reg, err_next;

    logic [7:0]        mem [WINDOW_DEPTH];
    logic [7:0]        mem_rdata_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [SIZE_W-1:0] src_pos;
    logic              out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign src_pos  = pos_reg - {{(SIZE_W-DIST_W){1'b0}}, dist_reg};

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        dist_next    = dist_reg;
        cnt_next     = cnt_reg;
        done_next    = done_reg;
        far_next     = far_reg;
        m_valid_next = m_valid_reg && !m_ready;
        byte_next    = byte_reg;
        dv_next      = dv_reg;
        last_next    = last_reg;
        sd_next      = sd_reg;
        err_next     = err_reg;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = pos_reg[AW-1:0];
        mem_wdata    = far_reg ? 8'd0 : mem_rdata_reg;
        mem_re       = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    unique case (q_data.kind)
                        CMD_ERR: begin
                            m_valid_next = 1'b1;
                            byte_next    = 8'd0;
                            dv_next      = 1'b0;
                            last_next    = 1'b1;
                            sd_next      = 1'b0;
                            err_next     = 1'b1;
                        end
                        CMD_ZERO: begin
                            m_valid_next = 1'b1;
                            byte_next    = 8'd0;
                            dv_next      = 1'b0;
                            last_next    = 1'b1;
                            sd_next      = 1'b1;
                            err_next     = 1'b0;
                        end
                        CMD_LIT: begin
                            mem_we       = 1'b1;
                            mem_waddr    = q_data.pos[AW-1:0];
                            mem_wdata    = q_data.data;
                            m_valid_next = 1'b1;
                            byte_next    = q_data.data;
                            dv_next      = 1'b1;
                            last_next    = 1'b1;
                            sd_next      = q_data.done;
                            err_next     = 1'b0;
                        end
                        CMD_MATCH: begin
                            pos_next   = q_data.pos;
                            dist_next  = q_data.offset;
                            cnt_next   = q_data.count;
                            done_next  = q_data.done;
                            state_next = B_READ;
                        end
                    endcase
                end
            end
            B_READ: begin
                mem_re     = 1'b1;
                far_next   = {{(SIZE_W-DIST_W){1'b0}}, dist_reg} > pos_reg;
                state_next = B_EMIT;
            end
            B_EMIT: begin
                if (out_free) begin
                    mem_we       = 1'b1;
                    m_valid_next = 1'b1;
                    byte_next    = mem_wdata;
                    dv_next      = 1'b1;
                    last_next    = cnt_reg == CNT_W'(1);
                    sd_next      = (cnt_reg == CNT_W'(1)) && done_reg;
                    err_next     = 1'b0;
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = B_IDLE;
                    end else begin
                        pos_next   = pos_reg + SIZE_W'(1);
                        cnt_next   = cnt_reg - CNT_W'(1);
                        state_next = B_READ;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[src_pos[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        pos_reg  <= pos_next;
        dist_reg <= dist_next;
        cnt_reg  <= cnt_next;
        done_reg <= done_next;
        far_reg  <= far_next;
        byte_reg <= byte_next;
        dv_reg   <= dv_next;
        last_reg <= last_next;
        sd_reg   <= sd_next;
        err_reg  <= err_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = byte_reg;
    assign m_data_valid   = dv_reg;
    assign m_run_last     = last_reg;
    assign m_stream_done  = sd_reg;
    assign m_header_error = err_reg;

`ifndef SYNTHESIS
    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == B_IDLE) && q_valid && out_free)
        else $error("command popped outside idle");
    a_err_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && err_reg) |-> (!dv_reg && last_reg && !sd_reg))
        else $error("header error result carries data");
    a_emit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != B_IDLE) |-> (cnt_reg != '0))
        else $error("copy running with zero count");
    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_EMIT && out_free && cnt_reg == CNT_W'(1)) |=>
        (state_reg == B_IDLE && m_valid_reg && m_run_last))
        else $error("copy did not finish on its final byte");
`endif

endmodule

// ===== rtl/lz77_type10_decompressor.sv =====
// Top level of the LZ77 type-0x10 stream decompressor.
// Depends on lz77d_pkg, lz77d_front, lz77d_cmd_queue, lz77d_back.
//
//   channel | ports                                           | dir
//   --------+-------------------------------------------------+----
//   input   | s_valid s_ready s_in_byte s_frame_start         | in
//   result  | m_valid m_ready m_out_byte m_data_valid         | out
//           | m_run_last m_stream_done m_header_error         |
//
// Input bytes are taken one per cycle while the two-entry command queue has room.
// A literal, error or zero-size result leaves the cycle after its command is popped;
// a match first takes its command, then for each copied byte does a registered
// history read (B_READ), then output and write-back (B_EMIT), as an overlapping
// copy needs the byte just written.
// aresetn is synchronous; the history needs no clearing pass.
// Either side may stall: the queue and the result register decouple them.
`timescale 1ns / 1ps

module lz77_type10_decompressor
    import lz77d_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_frame_start,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_data_valid,
    output logic       m_run_last,
    output logic       m_stream_done,
    output logic       m_header_error
);

    logic q_full, q_push, q_pop, q_valid;
    cmd_t q_push_data, q_pop_data;

    lz77d_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_frame_start (s_frame_start),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_push_data   (q_push_data)
    );

    lz77d_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_pop_data)
    );

    lz77d_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_data         (q_pop_data),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_data_valid   (m_data_valid),
        .m_run_last     (m_run_last),
        .m_stream_done  (m_stream_done),
        .m_header_error (m_header_error)
    );

endmodule

// ===== verif/lz77d_checker.sv =====
// Scoreboard for the LZ77 type-0x10 decompressor: watches both channels,
// decodes every accepted input byte itself and compares each result transfer.
// Depends on lz77d_pkg.
`timescale 1ns / 1ps

module lz77d_checker
    import lz77d_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_frame_start,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_data_valid,
    input  logic       m_run_last,
    input  logic       m_stream_done,
    input  logic       m_header_error,
    output int         errors,
    output int         outstanding,
    output int         checked
);

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_SIZE0,
        ST_SIZE1,
        ST_SIZE2,
        ST_FLAG,
        ST_TOKEN,
        ST_MATCH_LO
    } dec_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic       done;
        logic       err;
    } out_rec_t;

    dec_state_t  state;
    logic [7:0]  flags;
    logic [3:0]  bits_left;
    logic [23:0] total;
    logic [23:0] written;
    logic [7:0]  match_hi;
    logic [7:0]  hist [0:WINDOW_DEPTH_DEF-1];
    out_rec_t    expected_out [$];

    initial begin
        errors      = 0;
        outstanding = 0;
        checked     = 0;
    end

    task automatic push_rec(input logic [7:0] d, input logic v, input logic l,
                            input logic dn, input logic e);
        out_rec_t r;
        r.data  = d;
        r.valid = v;
        r.last  = l;
        r.done  = dn;
        r.err   = e;
        expected_out.push_back(r);
    endtask

    task automatic put_byte(input logic [7:0] v);
        hist[written[11:0]] = v;
        written = written + 24'd1;
        push_rec(v, 1'b1, 1'b0, written == total, 1'b0);
    endtask

    task automatic next_token();
        flags = flags << 1;
        if (bits_left != 4'd0) bits_left = bits_left - 4'd1;
        if (written >= total) state = ST_WAIT;
        else if (bits_left == 4'd0) state = ST_FLAG;
        else state = ST_TOKEN;
    endtask

    task automatic inflate_byte(input logic [7:0] b, input logic start);
        int          n0;
        int          left;
        logic [12:0] back;
        logic [23:0] at;
        logic [7:0]  v;
        out_rec_t    r;
        n0 = expected_out.size();
        if (start) begin
            flags     = 8'd0;
            bits_left = 4'd0;
            total     = 24'd0;
            written   = 24'd0;
            match_hi  = 8'd0;
            if (b == HDR_MAGIC) begin
                state = ST_SIZE0;
            end else begin
                state = ST_WAIT;
                push_rec(8'd0, 1'b0, 1'b0, 1'b0, 1'b1);
            end
        end else begin
            case (state)
                ST_SIZE0: begin
                    total = {16'd0, b};
                    state = ST_SIZE1;
                end
                ST_SIZE1: begin
                    total[15:8] = b;
                    state = ST_SIZE2;
                end
                ST_SIZE2: begin
                    total[23:16] = b;
                    if (total == 24'd0) begin
                        state = ST_WAIT;
                        push_rec(8'd0, 1'b0, 1'b0, 1'b1, 1'b0);
                    end else begin
                        state = ST_FLAG;
                    end
                end
                ST_FLAG: begin
                    flags     = b;
                    bits_left = FLAG_BITS;
                    state     = ST_TOKEN;
                end
                ST_TOKEN: begin
                    if (flags[7]) begin
                        match_hi = b;
                        state    = ST_MATCH_LO;
                    end else begin
                        put_byte(b);
                        next_token();
                    end
                end
                ST_MATCH_LO: begin
                    left = int'(match_hi[7:4]) + int'(MIN_MATCH);
                    back = {1'b0, match_hi[3:0], b} + 13'd1;
                    while (left > 0 && written < total) begin
                        v = 8'd0;
                        if ({11'd0, back} <= written) begin
                            at = written - {11'd0, back};
                            v  = hist[at[11:0]];
                        end
                        put_byte(v);
                        left--;
                    end
                    next_token();
                end
                default: ;
            endcase
        end
        // flag the final result of this byte
        if (expected_out.size() > n0) begin
            r = expected_out.pop_back();
            r.last = 1'b1;
            expected_out.push_back(r);
        end
    endtask

    task automatic check_result();
        out_rec_t e;
        checked++;
        if (expected_out.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result transfer %0d: byte=%02h dv=%b last=%b done=%b err=%b",
                         checked, m_out_byte, m_data_valid, m_run_last, m_stream_done,
                         m_header_error);
        end else begin
            e = expected_out.pop_front();
            if (m_out_byte !== e.data || m_data_valid !== e.valid || m_run_last !== e.last ||
                m_stream_done !== e.done || m_header_error !== e.err) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch at result %0d: exp byte=%02h dv=%b last=%b done=%b err=%b, got byte=%02h dv=%b last=%b done=%b err=%b",
                             checked, e.data, e.valid, e.last, e.done, e.err,
                             m_out_byte, m_data_valid, m_run_last, m_stream_done,
                             m_header_error);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            state     = ST_WAIT;
            flags     = 8'd0;
            bits_left = 4'd0;
            total     = 24'd0;
            written   = 24'd0;
            match_hi  = 8'd0;
            outstanding <= 0;
        end else begin
            if (s_valid && s_ready) inflate_byte(s_in_byte, s_frame_start);
            if (m_valid && m_ready) check_result();
            outstanding <= expected_out.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// Top of the decompressor testbench: clock, reset, byte stream stimulus with
// random idling and a long output stall, and the final verdict.
// Depends on lz77d_pkg, lz77_type10_decompressor and lz77d_checker.
`timescale 1ns / 1ps

module tb;
    import lz77d_pkg::*;

    localparam int LIMIT      = 400000;
    localparam int RAND_ITEMS = 330;
    localparam int HOLD_LEN   = 400;
    localparam int HOLD_AT    = 200;

    typedef struct packed {
        logic [7:0] b;
        logic       start;
    } stim_item_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       s_frame_start;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_data_valid;
    logic       m_run_last;
    logic       m_stream_done;
    logic       m_header_error;

    int         errors;
    int         outstanding;
    int         checked;
    int         sent;
    int         cycles;
    int         n_frames;
    int         n_bad;
    logic       quiet;
    stim_item_t stim_q [$];

    assign quiet = (sent >= 40) && (sent < 150);

    lz77_type10_decompressor dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_frame_start  (s_frame_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_data_valid   (m_data_valid),
        .m_run_last     (m_run_last),
        .m_stream_done  (m_stream_done),
        .m_header_error (m_header_error)
    );

    lz77d_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_frame_start  (s_frame_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_data_valid   (m_data_valid),
        .m_run_last     (m_run_last),
        .m_stream_done  (m_stream_done),
        .m_header_error (m_header_error),
        .errors         (errors),
        .outstanding    (outstanding),
        .checked        (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic add_item(input logic [7:0] b, input logic st);
        stim_item_t it;
        it.b     = b;
        it.start = st;
        stim_q.push_back(it);
    endtask

    // cut < 0 builds a complete frame, otherwise it stops after cut tokens
    task automatic gen_frame(input logic [23:0] sz, input int cut);
        int          made;
        int          tokens;
        int          k;
        logic [7:0]  fl;
        logic [11:0] back;
        logic [3:0]  len;
        add_item(HDR_MAGIC, 1'b1);
        add_item(sz[7:0], 1'b0);
        add_item(sz[15:8], 1'b0);
        add_item(sz[23:16], 1'b0);
        n_frames++;
        made   = 0;
        tokens = 0;
        while (made < int'(sz) && (cut < 0 || tokens < cut)) begin
            fl = 8'($urandom_range(255));
            add_item(fl, 1'b0);
            k = 7;
            while (k >= 0 && made < int'(sz) && (cut < 0 || tokens < cut)) begin
                if (fl[k]) begin
                    len = 4'($urandom_range(15));
                    if (made > 0 && $urandom_range(99) < 80)
                        back = 12'($urandom_range(made > 4096 ? 4095 : made - 1));
                    else
                        back = 12'($urandom_range(4095));
                    add_item({len, back[11:8]}, 1'b0);
                    add_item(back[7:0], 1'b0);
                    made += int'(len) + 3;
                end else begin
                    add_item(8'($urandom_range(255)), 1'b0);
                    made++;
                end
                tokens++;
                k--;
            end
        end
    endtask

    task automatic add_junk(input int n);
        int i;
        for (i = 0; i < n; i++) add_item(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic build_stimulus();
        int          r;
        logic [7:0]  hb;
        logic [23:0] sz;
        // directed: idle byte, bad header and its ignored tail, zero size
        add_item(8'hFF, 1'b0);
        add_item(8'hEF, 1'b1);
        add_item(HDR_MAGIC, 1'b0);
        n_bad++;
        add_item(HDR_MAGIC, 1'b1);
        add_item(8'h00, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'h00, 1'b0);
        // size 20: literal, overlapping copy, far copy cut short by the size
        add_item(HDR_MAGIC, 1'b1);
        add_item(8'h14, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'h60, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'hF0, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'h33, 1'b0);
        // maximum size, then a restart with a bad header mid-frame
        add_item(HDR_MAGIC, 1'b1);
        add_item(8'hFF, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'h5A, 1'b0);
        add_item(8'h11, 1'b1);
        n_bad++;
        n_frames += 3;

        while (stim_q.size() < RAND_ITEMS) begin
            r = $urandom_range(99);
            if (r < 70) begin
                if ($urandom_range(9) == 0) sz = 24'($urandom_range(400, 100));
                else sz = 24'($urandom_range(60, 1));
                gen_frame(sz, -1);
                if ($urandom_range(99) < 30) add_junk($urandom_range(3, 1));
            end else if (r < 80) begin
                sz = 24'($urandom);
                gen_frame(sz, $urandom_range(6));
            end else if (r < 88) begin
                hb = 8'($urandom_range(255));
                if (hb == HDR_MAGIC) hb = hb ^ 8'h01;
                add_item(hb, 1'b1);
                n_bad++;
                add_junk($urandom_range(3));
            end else if (r < 93) begin
                gen_frame(24'd0, -1);
            end else begin
                add_junk($urandom_range(3, 1));
            end
        end
    endtask

    initial begin : sender
        int   idx;
        logic acc;
        s_valid       = 1'b0;
        s_in_byte     = 8'd0;
        s_frame_start = 1'b0;
        sent          = 0;
        n_frames      = 0;
        n_bad         = 0;
        idx           = 0;
        build_stimulus();
        while (aresetn !== 1'b1) @(posedge aclk);
        while (idx < stim_q.size()) begin
            @(posedge aclk);
            acc = s_valid && s_ready;
            if (acc) idx++;
            sent <= idx;
            if (!s_valid || acc) begin
                if (idx < stim_q.size() && (quiet || $urandom_range(99) >= 22)) begin
                    s_valid       <= 1'b1;
                    s_in_byte     <= stim_q[idx].b;
                    s_frame_start <= stim_q[idx].start;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    initial begin : receiver
        int hold;
        bit held;
        m_ready = 1'b0;
        hold    = 0;
        held    = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && sent >= HOLD_AT) begin
                hold = HOLD_LEN;
                held = 1'b1;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= 22);
            end
        end
    end

    initial cycles = 0;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected", cycles, outstanding);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : main
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (stim_q.size() == 0 || sent < stim_q.size()) @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Sent %0d input transfers in %0d frames (%0d bad headers).",
                 sent, n_frames, n_bad);
        $display("Checked %0d result transfers, %0d failures.", checked, errors);
        if (errors == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== lz77_type10_decompressor.f =====
rtl/lz77d_pkg.sv
rtl/lz77d_front.sv
rtl/lz77d_cmd_queue.sv
rtl/lz77d_back.sv
rtl/lz77_type10_decompressor.sv
verif/lz77d_checker.sv
verif/tb.sv
